[hdl/bia_pkg.sv]
// Package for the bitmap id allocator: field widths, action and status codes,
// default geometry and the controller state type. No dependencies.
`default_nettype none
package bia_pkg;

  localparam int ACT_W    = 2;
  localparam int ID_IN_W  = 12;
  localparam int ID_OUT_W = 11;
  localparam int STATUS_W = 3;

  localparam int MAP_WORDS_DEF = 32;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [ACT_W-1:0] ACT_ASSIGN = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ASSIGNED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ASG_ID,
    S_FREE_DIV,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[hdl/bia_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; contents are undefined until written.
`default_nettype none
module bia_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/bitmap_id_allocator.sv]
// Bitmap id allocator over a map in one RAM (bia_ram), codes from bia_pkg.
// Assign scans the map word by word, skipping full words, then forms the id;
// free computes the quotient, reads the word and writes it back, and stops
// after the read when ignored; clear and unknown actions go straight to the result.
// One item at a time: the next is taken in the cycle after the result is loaded.
// Reset and clear empty the map at once through per-word valid flags.
`default_nettype none
module bitmap_id_allocator #(
  parameter int MAP_WORDS = bia_pkg::MAP_WORDS_DEF,
  parameter int WORD_BITS = bia_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bia_pkg::ACT_W-1:0]     action,
  input  logic [bia_pkg::ID_IN_W-1:0]   id_to_free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bia_pkg::ID_OUT_W-1:0]  assigned_id,
  output logic [bia_pkg::STATUS_W-1:0]  status
);
  import bia_pkg::*;

  localparam int AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int SLOT_W = $clog2(MAP_WORDS * WORD_BITS) + 1;
  localparam int SUM_W  = ((SLOT_W > ID_OUT_W) ? SLOT_W : ID_OUT_W) + 1;
  // Reciprocal for slot / WORD_BITS, exact for every ID_IN_W-bit slot
  localparam int DIV_SH = ID_IN_W + BW;
  localparam int RECIP  = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W = DIV_SH + ID_IN_W;
  localparam logic [AW-1:0]      LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [ID_IN_W:0]   WORDS_L   = (ID_IN_W + 1)'(MAP_WORDS);

  state_t               state, state_next;
  logic [ID_IN_W-1:0]   id_q;
  logic [AW-1:0]        word_cnt, word_cnt_next;
  logic [SLOT_W-1:0]    base, base_next;
  logic [ID_IN_W-1:0]   quot, quot_next;
  logic [BW-1:0]        bit_q, bit_q_next;
  logic [WORD_BITS-1:0] onehot, onehot_next;
  logic [ID_OUT_W-1:0]  res_id, res_id_next;
  logic [STATUS_W-1:0]  res_status, res_status_next;
  logic [MAP_WORDS-1:0] wvalid, wvalid_next;
  logic                 vld_q;
  logic                 out_load;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [WORD_BITS-1:0] word;
  logic [ID_IN_W-1:0]   slot;
  logic [PROD_W-1:0]    prod;
  logic [ID_IN_W-1:0]   rem_full;
  logic [BW-1:0]        enc_idx;
  logic [SUM_W-1:0]     id_sum;

  bia_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .ADDR_W(AW)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign word     = vld_q ? ram_rdata : '0;
  assign slot     = id_q - ID_IN_W'(1);
  assign prod     = PROD_W'(slot) * PROD_W'(RECIP);
  assign rem_full = slot - ID_IN_W'(quot * ID_IN_W'(WORD_BITS));
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    enc_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        enc_idx = enc_idx | BW'(i);
      end
    end
  end

  assign id_sum = SUM_W'(base) + SUM_W'(enc_idx) + SUM_W'(1);

  always_comb begin
    state_next      = state;
    word_cnt_next   = word_cnt;
    base_next       = base;
    quot_next       = quot;
    bit_q_next      = bit_q;
    onehot_next     = onehot;
    res_id_next     = res_id;
    res_status_next = res_status;
    wvalid_next     = wvalid;
    ram_we          = 1'b0;
    ram_waddr       = word_cnt;
    ram_wdata       = word;
    ram_raddr       = word_cnt;

    unique case (state)
      S_IDLE: begin
        // word 0 is read here so the scan starts with data in hand
        ram_raddr     = '0;
        word_cnt_next = '0;
        base_next     = '0;
        res_id_next   = '0;
        if (in_valid) begin
          unique case (action)
            ACT_ASSIGN: state_next = S_SCAN;
            ACT_FREE:   state_next = S_FREE_DIV;
            ACT_CLEAR: begin
              wvalid_next     = '0;
              res_status_next = ST_CLEARED;
              state_next      = S_DONE;
            end
            default: begin
              res_status_next = ST_IGNORED;
              state_next      = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // fetch the following word while this one is checked
        ram_raddr = word_cnt + AW'(1);
        if (word == '1) begin
          if (word_cnt == LAST_WORD) begin
            res_status_next = ST_FULL;
            state_next      = S_DONE;
          end else begin
            word_cnt_next = word_cnt + AW'(1);
            base_next     = base + SLOT_W'(WORD_BITS);
          end
        end else begin
          onehot_next             = ~word & (word + WORD_BITS'(1));
          ram_we                  = 1'b1;
          ram_wdata               = word | (~word & (word + WORD_BITS'(1)));
          wvalid_next[word_cnt]   = 1'b1;
          state_next              = S_ASG_ID;
        end
      end
      S_ASG_ID: begin
        res_id_next     = id_sum[ID_OUT_W-1:0];
        res_status_next = ST_ASSIGNED;
        state_next      = S_DONE;
      end
      S_FREE_DIV: begin
        quot_next  = prod[DIV_SH +: ID_IN_W];
        state_next = S_FREE_RD;
      end
      S_FREE_RD: begin
        ram_raddr     = quot[AW-1:0];
        word_cnt_next = quot[AW-1:0];
        bit_q_next    = rem_full[BW-1:0];
        if (id_q == '0 || {1'b0, quot} >= WORDS_L) begin
          res_status_next = ST_IGNORED;
          state_next      = S_DONE;
        end else begin
          state_next = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        ram_we                = 1'b1;
        ram_wdata             = word & ~(WORD_BITS'(1) << bit_q);
        wvalid_next[word_cnt] = 1'b1;
        res_status_next       = ST_FREED;
        state_next            = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      wvalid <= wvalid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_cnt   <= word_cnt_next;
    base       <= base_next;
    quot       <= quot_next;
    bit_q      <= bit_q_next;
    onehot     <= onehot_next;
    res_id     <= res_id_next;
    res_status <= res_status_next;
    vld_q      <= wvalid[ram_raddr];
    if (state == S_IDLE && in_valid) begin
      id_q <= id_to_free;
    end
    if (out_load) begin
      assigned_id <= res_id;
      status      <= res_status;
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for bitmap_id_allocator: directed table, then random
// assign/free/clear/unknown traffic checked against an in-bench allocator predictor.
// Depends on bia_pkg for widths, action and status codes and the map geometry.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bia_pkg::*;

  localparam int     CLK_PERIOD   = 20;
  localparam int     CAPACITY     = MAP_WORDS_DEF * WORD_BITS_DEF;
  localparam int     HOLD_CYCLES  = 200;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     MAX_LINES    = 40;
  localparam longint TIMEOUT_NS   = 15_000_000;
  localparam int     DIR_N        = 23;

  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [ID_OUT_W-1:0] id;
    logic [STATUS_W-1:0] st;
  } alloc_resp_t;

  typedef struct packed {
    logic [ACT_W-1:0]    act;
    logic [ID_IN_W-1:0]  id;
    logic                typed;
    logic [ID_OUT_W-1:0] eid;
    logic [STATUS_W-1:0] est;
  } dir_row_t;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [ACT_W-1:0]    action     = ACT_ASSIGN;
  logic [ID_IN_W-1:0]  id_to_free = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [ID_OUT_W-1:0] assigned_id;
  logic [STATUS_W-1:0] status;

  // Item currently offered: typed expectation, if the table row carries one.
  logic        row_typed = 1'b0;
  alloc_resp_t row_resp  = '0;

  logic        hold_req  = 1'b0;
  int          send_pct  = 0;
  int          recv_pct  = 0;
  int          err_count = 0;

  logic [WORD_BITS_DEF-1:0] used_map [MAP_WORDS_DEF];
  int                       used_count;
  alloc_resp_t              resp_due_q [$];

  // Extremes, every action and each special case; typed where obvious.
  dir_row_t dir_rows [DIR_N] = '{
    '{ACT_ASSIGN,  12'd0,    1'b1, 11'd1, ST_ASSIGNED},
    '{ACT_ASSIGN,  12'd4095, 1'b1, 11'd2, ST_ASSIGNED},
    '{ACT_ASSIGN,  12'd0,    1'b1, 11'd3, ST_ASSIGNED},
    '{ACT_FREE,    12'd0,    1'b1, 11'd0, ST_IGNORED},
    '{ACT_FREE,    12'd4095, 1'b1, 11'd0, ST_IGNORED},
    '{ACT_FREE,    12'd1025, 1'b1, 11'd0, ST_IGNORED},
    '{ACT_FREE,    12'd1024, 1'b1, 11'd0, ST_FREED},
    '{ACT_FREE,    12'd2,    1'b1, 11'd0, ST_FREED},
    '{ACT_ASSIGN,  12'd0,    1'b1, 11'd2, ST_ASSIGNED},
    '{ACT_UNKNOWN, 12'd4095, 1'b1, 11'd0, ST_IGNORED},
    '{ACT_UNKNOWN, 12'd0,    1'b1, 11'd0, ST_IGNORED},
    '{ACT_FREE,    12'hAAA,  1'b1, 11'd0, ST_IGNORED},
    '{ACT_FREE,    12'h555,  1'b1, 11'd0, ST_IGNORED},
    '{ACT_FREE,    12'd3,    1'b0, 11'd0, ST_FREED},
    '{ACT_FREE,    12'd3,    1'b0, 11'd0, ST_FREED},
    '{ACT_ASSIGN,  12'd0,    1'b0, 11'd0, ST_ASSIGNED},
    '{ACT_CLEAR,   12'd4095, 1'b1, 11'd0, ST_CLEARED},
    '{ACT_ASSIGN,  12'd0,    1'b1, 11'd1, ST_ASSIGNED},
    '{ACT_FREE,    12'd1,    1'b1, 11'd0, ST_FREED},
    '{ACT_ASSIGN,  12'd2047, 1'b0, 11'd0, ST_ASSIGNED},
    '{ACT_FREE,    12'h3FF,  1'b0, 11'd0, ST_FREED},
    '{ACT_FREE,    12'h400,  1'b0, 11'd0, ST_FREED},
    '{ACT_CLEAR,   12'd0,    1'b1, 11'd0, ST_CLEARED}
  };

  bitmap_id_allocator u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .id_to_free  (id_to_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .assigned_id (assigned_id),
    .status      (status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic flag_error(input string msg);
    if (err_count < MAX_LINES) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // First-free allocation over the map words, plus free and clear; updates the shadow map.
  function automatic void alloc_predict(input logic [ACT_W-1:0] act,
                                        input logic [ID_IN_W-1:0] id,
                                        output alloc_resp_t resp);
    int  slot;
    int  w;
    int  b;
    bit  found;
    resp.id = '0;
    resp.st = ST_IGNORED;
    found   = 1'b0;
    case (act)
      ACT_ASSIGN: begin
        resp.st = ST_FULL;
        for (w = 0; w < MAP_WORDS_DEF && !found; w++) begin
          if (used_map[w] != '1) begin
            for (b = 0; b < WORD_BITS_DEF && !found; b++) begin
              if (!used_map[w][b]) begin
                used_map[w][b] = 1'b1;
                used_count++;
                resp.id = ID_OUT_W'(w * WORD_BITS_DEF + b + 1);
                resp.st = ST_ASSIGNED;
                found   = 1'b1;
              end
            end
          end
        end
      end
      ACT_FREE: begin
        slot = int'(id) - 1;
        if (id != '0 && slot / WORD_BITS_DEF < MAP_WORDS_DEF) begin
          w = slot / WORD_BITS_DEF;
          b = slot % WORD_BITS_DEF;
          if (used_map[w][b]) used_count--;
          used_map[w][b] = 1'b0;
          resp.st = ST_FREED;
        end
      end
      ACT_CLEAR: begin
        foreach (used_map[i]) used_map[i] = '0;
        used_count = 0;
        resp.st    = ST_CLEARED;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    alloc_resp_t want;
    if (rst) begin
      foreach (used_map[i]) used_map[i] = '0;
      used_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (resp_due_q.size() == 0) begin
          flag_error($sformatf("unexpected result id %0d status %0d", assigned_id, status));
        end else begin
          want = resp_due_q.pop_front();
          if (assigned_id !== want.id)
            flag_error($sformatf("assigned_id %0d, want %0d", assigned_id, want.id));
          if (status !== want.st)
            flag_error($sformatf("status %0d, want %0d", status, want.st));
        end
      end
      if (in_valid && !in_stall) begin
        alloc_predict(action, id_to_free, want);
        if (row_typed) want = row_resp;
        resp_due_q.push_back(want);
      end
    end
  end

  // Receiver: random stall, or a long hold-off when asked.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
      end
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_pct = 0;  recv_pct <= 0;  end
      IDLE_SEND: begin send_pct = 82; recv_pct <= 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct <= 82; end
      default:   begin send_pct = 28; recv_pct <= 28; end
    endcase
  endtask

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [ID_IN_W-1:0] id,
                           input logic typed = 1'b0, input alloc_resp_t fixed_resp = '0);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    id_to_free <= id;
    row_typed  <= typed;
    row_resp   <= fixed_resp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (resp_due_q.size() != 0) @(negedge clk);
  endtask

  // Mostly ids near the occupied range, with zero and out-of-range mixed in.
  function automatic logic [ID_IN_W-1:0] pick_free_id();
    int r;
    int hi;
    r  = $urandom_range(99);
    hi = (used_count + 4 > CAPACITY) ? CAPACITY : used_count + 4;
    if (r < 70) return ID_IN_W'($urandom_range(hi, 1));
    if (r < 78) return '0;
    if (r < 88) return ID_IN_W'($urandom_range(4095, CAPACITY + 1));
    return ID_IN_W'($urandom_range(CAPACITY, 1));
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 45)      send_item(ACT_ASSIGN, ID_IN_W'($urandom));
    else if (r < 85) send_item(ACT_FREE, pick_free_id());
    else if (r < 92) send_item(ACT_CLEAR, ID_IN_W'($urandom));
    else             send_item(ACT_UNKNOWN, ID_IN_W'($urandom));
  endtask

  initial begin : stimulus
    int n;
    int r;
    set_idling(IDLE_NONE);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].id, dir_rows[i].typed,
                alloc_resp_t'{dir_rows[i].eid, dir_rows[i].est});

    set_idling(IDLE_SEND);
    repeat (150) random_item();

    // Hold the result side off while items keep coming, so the input stalls.
    set_idling(IDLE_RECV);
    hold_req <= 1'b1;
    repeat (152) random_item();

    // Fill the map to the top from empty, rotating the idling pattern.
    send_item(ACT_CLEAR, ID_IN_W'($urandom));
    n = 0;
    while (used_count < CAPACITY) begin
      if (n % 256 == 0) set_idling(idle_mode_t'((n / 256) % 4));
      if ($urandom_range(99) < 4) send_item(ACT_FREE, pick_free_id());
      else                        send_item(ACT_ASSIGN, ID_IN_W'($urandom));
      n++;
    end
    set_idling(IDLE_BOTH);
    repeat (6) send_item(ACT_ASSIGN, ID_IN_W'($urandom));

    // Churn around a full map: free scattered ids and take them back.
    repeat (150) begin
      r = $urandom_range(99);
      if (r < 45)      send_item(ACT_FREE, ID_IN_W'($urandom_range(CAPACITY, 1)));
      else if (r < 92) send_item(ACT_ASSIGN, ID_IN_W'($urandom));
      else if (r < 96) send_item(ACT_FREE, ID_IN_W'($urandom_range(4095, CAPACITY + 1)));
      else             send_item(ACT_UNKNOWN, ID_IN_W'($urandom));
    end

    // Pause until every result is back, then run flat out.
    in_valid <= 1'b0;
    drain_results();
    set_idling(IDLE_NONE);
    repeat (100) random_item();

    in_valid <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("TB_ERROR");
    $finish;
  end

endmodule
